>>> rtl/sfa_pkg.sv
// Package with the shared types, opcodes and command codes of the spring force accumulator.
package sfa_pkg;

    localparam logic [1:0] OP_ACCUMULATE = 2'd0;
    localparam logic [1:0] OP_READ       = 2'd1;
    localparam logic [1:0] OP_READ_CLEAR = 2'd2;

    localparam int unsigned REG_COUNT = 8;
    localparam logic [30:0] REG_RESET = 31'd65536;
    localparam logic signed [49:0] FORCE_MAX = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [49:0] FORCE_MIN = -50'sh0_8000_0000_0000;
    localparam logic [47:0] MAG_POS_LIMIT = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] MAG_NEG_LIMIT = 48'h8000_0000_0000;
    localparam int unsigned SQRT_STEPS = 32;
    localparam int unsigned DIV_STEPS  = 64;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [9:0]         first_vertex;
        logic [9:0]         second_vertex;
        logic [1:0]         spring_type;
        logic signed [31:0] first_pos_x;
        logic signed [31:0] first_pos_y;
        logic signed [31:0] first_pos_z;
        logic signed [31:0] second_pos_x;
        logic signed [31:0] second_pos_y;
        logic signed [31:0] second_pos_z;
    } item_t;

    typedef struct packed {
        logic [9:0]         vertex_read;
        logic signed [47:0] force_x;
        logic signed [47:0] force_y;
        logic signed [47:0] force_z;
        logic               saturated;
    } result_t;

    typedef struct packed {
        logic               mark;
        logic signed [47:0] z;
        logic signed [47:0] y;
        logic signed [47:0] x;
    } row_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_CLEAR,
        DP_SQUARE,
        DP_SQRT,
        DP_KR,
        DP_DIV,
        DP_FORCE,
        DP_MUL_LO,
        DP_MUL_HI,
        DP_FINISH,
        DP_MEM_READ,
        DP_MEM_ACC,
        DP_OUTPUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] idx;
        logic       sel_b;
    } dp_cmd_t;

    typedef struct packed {
        logic acc_ok;
        logic is_read;
        logic r_zero;
        logic clear_done;
    } dp_status_t;

endpackage

>>> rtl/sfa_datapath.sv
// Datapath of the spring force accumulator: registers, multiplier, root and divide steps, memory.
module sfa_datapath
    import sfa_pkg::*;
#(
    parameter int VERTEX_COUNT = 1024,
    parameter int SPRING_TYPES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  item_t       item,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_data,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    output result_t     result,
    output logic        result_valid
);

    localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;

    row_t mem [VERTEX_COUNT];

    logic [30:0] k_reg [4];
    logic [30:0] rest_reg [4];
    item_t in_reg;
    logic rd_ok_reg;
    logic [63:0] s_reg, prod_reg, pacc_reg;
    logic [31:0] root_reg;
    logic [33:0] rem_reg;
    logic signed [62:0] f_reg;
    logic signed [47:0] force_reg [3];
    logic clip_reg;
    row_t rdata_reg;
    logic [AW-1:0] clr_cnt_reg;
    result_t result_reg;
    logic result_valid_reg;

    logic [31:0] d_mag [3];
    logic d_neg [3];
    logic signed [32:0] d_val [3];
    logic [31:0] mul_a, mul_b, dm_sel;
    logic [63:0] prod_next;
    logic [35:0] sq_rem2, sq_trial;
    logic [32:0] dv_rem2;
    logic [61:0] f_mag;
    logic [95:0] p_full;
    logic [79:0] p_shift;
    logic [47:0] m_lim, m_val;
    logic neg_sel, mag_clip;
    logic [AW-1:0] mem_addr;
    logic mem_we, mem_re;
    row_t mem_wdata, acc_row;
    logic acc_clip [3];
    logic signed [49:0] acc_sum [3];
    logic signed [49:0] acc_add [3];
    logic signed [47:0] acc_old [3];
    logic [1:0] ty;

    assign ty = in_reg.spring_type;

    always_comb
    begin
        d_val[0] = 33'(in_reg.second_pos_x) - 33'(in_reg.first_pos_x);
        d_val[1] = 33'(in_reg.second_pos_y) - 33'(in_reg.first_pos_y);
        d_val[2] = 33'(in_reg.second_pos_z) - 33'(in_reg.first_pos_z);
        for (int i = 0; i < 3; i++)
        begin
            d_neg[i] = d_val[i][32];
            d_mag[i] = d_val[i][32] ? 32'(-d_val[i]) : d_val[i][31:0];
        end
    end

    always_comb
    begin
        unique case (cmd.idx)
            2'd0: begin dm_sel = d_mag[0]; neg_sel = d_neg[0]; end
            2'd1: begin dm_sel = d_mag[1]; neg_sel = d_neg[1]; end
            2'd2: begin dm_sel = d_mag[2]; neg_sel = d_neg[2]; end
            default: begin dm_sel = '0; neg_sel = 1'b0; end
        endcase
        neg_sel = neg_sel ^ f_reg[62];
    end

    assign f_mag = f_reg[62] ? 62'(-f_reg) : f_reg[61:0];

    always_comb
    begin
        unique case (cmd.op)
            DP_SQUARE: begin mul_a = dm_sel; mul_b = dm_sel; end
            DP_KR: begin mul_a = {1'b0, k_reg[ty]}; mul_b = {2'b0, rest_reg[ty][30:1]}; end
            DP_MUL_LO: begin mul_a = f_mag[31:0]; mul_b = dm_sel; end
            DP_MUL_HI: begin mul_a = {2'b0, f_mag[61:32]}; mul_b = dm_sel; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        prod_next = 64'(mul_a) * 64'(mul_b);
    end

    assign sq_rem2  = {rem_reg, s_reg[63:62]};
    assign sq_trial = {2'b0, root_reg, 2'b01};
    assign dv_rem2  = {rem_reg[31:0], prod_reg[63]};

    always_comb
    begin
        p_full  = {32'b0, pacc_reg} + {prod_reg, 32'b0};
        p_shift = p_full[95:16];
        m_lim   = neg_sel ? MAG_NEG_LIMIT : MAG_POS_LIMIT;
        mag_clip = p_shift > 80'(m_lim);
        m_val   = mag_clip ? m_lim : p_shift[47:0];
    end

    always_comb
    begin
        acc_old[0] = rdata_reg.x;
        acc_old[1] = rdata_reg.y;
        acc_old[2] = rdata_reg.z;
        acc_row = rdata_reg;
        for (int i = 0; i < 3; i++)
        begin
            acc_add[i] = cmd.sel_b ? -50'(force_reg[i]) : 50'(force_reg[i]);
            acc_sum[i] = 50'(acc_old[i]) + acc_add[i];
            acc_clip[i] = (acc_sum[i] > FORCE_MAX) || (acc_sum[i] < FORCE_MIN);
            if (acc_sum[i] > FORCE_MAX)
            begin
                acc_sum[i] = FORCE_MAX;
            end
            else if (acc_sum[i] < FORCE_MIN)
            begin
                acc_sum[i] = FORCE_MIN;
            end
        end
        acc_row.x = acc_sum[0][47:0];
        acc_row.y = acc_sum[1][47:0];
        acc_row.z = acc_sum[2][47:0];
        acc_row.mark = rdata_reg.mark | acc_clip[0] | acc_clip[1] | acc_clip[2] | clip_reg;
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_wdata = '0;
        mem_addr = cmd.sel_b ? AW'(in_reg.second_vertex) : AW'(in_reg.first_vertex);
        unique case (cmd.op)
            DP_CLEAR:
            begin
                mem_we = 1'b1;
                mem_addr = clr_cnt_reg;
            end
            DP_MEM_READ: mem_re = 1'b1;
            DP_MEM_ACC:
            begin
                mem_we = 1'b1;
                mem_wdata = acc_row;
            end
            DP_OUTPUT: mem_we = rd_ok_reg && (in_reg.opcode == OP_READ_CLEAR);
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    always_comb
    begin
        status.acc_ok = (item.opcode == OP_ACCUMULATE)
            && (32'(item.first_vertex) < VERTEX_COUNT)
            && (32'(item.second_vertex) < VERTEX_COUNT)
            && (32'(item.spring_type) < SPRING_TYPES);
        status.is_read = (item.opcode == OP_READ) || (item.opcode == OP_READ_CLEAR);
        status.r_zero = (root_reg == '0);
        status.clear_done = (clr_cnt_reg == AW'(VERTEX_COUNT - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                k_reg[i] <= REG_RESET;
                rest_reg[i] <= REG_RESET;
            end
            clr_cnt_reg <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index[2])
                begin
                    rest_reg[cfg_index[1:0]] <= cfg_data;
                end
                else
                begin
                    k_reg[cfg_index[1:0]] <= cfg_data;
                end
            end
            if (cmd.op == DP_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            result_valid_reg <= (cmd.op == DP_OUTPUT);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_LOAD:
            begin
                in_reg <= item;
                rd_ok_reg <= 32'(item.first_vertex) < VERTEX_COUNT;
            end
            DP_SQUARE:
            begin
                s_reg <= (cmd.idx == 2'd0) ? 64'd0 : s_reg + {2'b0, prod_reg[63:2]};
                prod_reg <= prod_next;
                root_reg <= '0;
                rem_reg <= '0;
            end
            DP_SQRT:
            begin
                s_reg <= {s_reg[61:0], 2'b00};
                if (sq_rem2 >= sq_trial)
                begin
                    rem_reg <= 34'(sq_rem2 - sq_trial);
                    root_reg <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= sq_rem2[33:0];
                    root_reg <= {root_reg[30:0], 1'b0};
                end
            end
            DP_KR:
            begin
                prod_reg <= prod_next;
                rem_reg <= '0;
            end
            DP_DIV:
            begin
                if (dv_rem2 >= {1'b0, root_reg})
                begin
                    rem_reg <= 34'(dv_rem2 - {1'b0, root_reg});
                    prod_reg <= {prod_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= 34'(dv_rem2);
                    prod_reg <= {prod_reg[62:0], 1'b0};
                end
            end
            DP_FORCE:
            begin
                f_reg <= $signed(63'(k_reg[ty])) - $signed(prod_reg[62:0]);
                clip_reg <= 1'b0;
            end
            DP_MUL_LO: prod_reg <= prod_next;
            DP_MUL_HI:
            begin
                pacc_reg <= prod_reg;
                prod_reg <= prod_next;
            end
            DP_FINISH:
            begin
                force_reg[cmd.idx] <= neg_sel ? 48'(-m_val) : m_val;
                clip_reg <= clip_reg | mag_clip;
            end
            DP_OUTPUT:
            begin
                result_reg.vertex_read <= in_reg.first_vertex;
                result_reg.force_x <= rd_ok_reg ? rdata_reg.x : '0;
                result_reg.force_y <= rd_ok_reg ? rdata_reg.y : '0;
                result_reg.force_z <= rd_ok_reg ? rdata_reg.z : '0;
                result_reg.saturated <= rd_ok_reg && rdata_reg.mark;
            end
            default: clip_reg <= clip_reg;
        endcase
    end

    assign result = result_reg;
    assign result_valid = result_valid_reg;

endmodule

>>> rtl/sfa_ctrl.sv
// Controller state machine that sequences the spring force accumulator datapath.
module sfa_ctrl
    import sfa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output logic       busy,
    output dp_cmd_t    cmd
);

    typedef enum logic [13:0] {
        S_CLEAR  = 14'b00000000000001,
        S_IDLE   = 14'b00000000000010,
        S_SQUARE = 14'b00000000000100,
        S_SQRT   = 14'b00000000001000,
        S_KR     = 14'b00000000010000,
        S_DIV    = 14'b00000000100000,
        S_FORCE  = 14'b00000001000000,
        S_MUL    = 14'b00000010000000,
        S_RD_A   = 14'b00000100000000,
        S_WR_A   = 14'b00001000000000,
        S_RD_B   = 14'b00010000000000,
        S_WR_B   = 14'b00100000000000,
        S_READ   = 14'b01000000000000,
        S_OUT    = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg + 1'b1;
        cmd.op = DP_NONE;
        cmd.idx = 2'd0;
        cmd.sel_b = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = DP_CLEAR;
                if (status.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cnt_next = '0;
                if (start)
                begin
                    cmd.op = DP_LOAD;
                    if (status.is_read)
                    begin
                        state_next = S_READ;
                    end
                    else if (status.acc_ok)
                    begin
                        state_next = S_SQUARE;
                    end
                end
            end
            S_SQUARE:
            begin
                cmd.op = DP_SQUARE;
                cmd.idx = cnt_reg[1:0];
                if (cnt_reg[1:0] == 2'd3)
                begin
                    state_next = S_SQRT;
                    cnt_next = '0;
                end
            end
            S_SQRT:
            begin
                cmd.op = DP_SQRT;
                if (cnt_reg == 6'(SQRT_STEPS - 1))
                begin
                    state_next = S_KR;
                end
            end
            S_KR:
            begin
                cmd.op = DP_KR;
                cnt_next = '0;
                state_next = status.r_zero ? S_IDLE : S_DIV;
            end
            S_DIV:
            begin
                cmd.op = DP_DIV;
                if (cnt_reg == 6'(DIV_STEPS - 1))
                begin
                    state_next = S_FORCE;
                end
            end
            S_FORCE:
            begin
                cmd.op = DP_FORCE;
                cnt_next = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.idx = cnt_reg[3:2];
                unique case (cnt_reg[1:0])
                    2'd0: cmd.op = DP_MUL_LO;
                    2'd1: cmd.op = DP_MUL_HI;
                    2'd2: cmd.op = DP_FINISH;
                    default: cmd.op = DP_NONE;
                endcase
                if (cnt_reg[3:0] == 4'd11)
                begin
                    state_next = S_RD_A;
                end
            end
            S_RD_A:
            begin
                cmd.op = DP_MEM_READ;
                state_next = S_WR_A;
            end
            S_WR_A:
            begin
                cmd.op = DP_MEM_ACC;
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                cmd.op = DP_MEM_READ;
                cmd.sel_b = 1'b1;
                state_next = S_WR_B;
            end
            S_WR_B:
            begin
                cmd.op = DP_MEM_ACC;
                cmd.sel_b = 1'b1;
                state_next = S_IDLE;
            end
            S_READ:
            begin
                cmd.op = DP_MEM_READ;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.op = DP_OUTPUT;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> rtl/spring_force_accumulator.sv
// Top level of the spring force accumulator: controller and datapath joined by command words.
// After reset the force store is cleared one row a cycle, with busy high, before any word is taken.
// A read word passes through the S_READ and S_OUT states and ends in the one-cycle result strobe.
// An accumulate word runs through the 32-step square root and the 64-step restoring divide;
// a zero length ends it after the root, before the divide.
// One word is in work at a time; the receiver cannot stall results.
module spring_force_accumulator
    import sfa_pkg::*;
#(
    parameter int VERTEX_COUNT = 1024,
    parameter int SPRING_TYPES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  item_t       item,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_data,
    output result_t     result,
    output logic        result_valid
);

    dp_cmd_t cmd;
    dp_status_t status;

    sfa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    sfa_datapath #(
        .VERTEX_COUNT (VERTEX_COUNT),
        .SPRING_TYPES (SPRING_TYPES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

>>> tb/sv/spring_force_checker.sv
// Checker for the spring force accumulator: predicts every read result and compares it.
`timescale 1ns / 1ps

module spring_force_checker
    import sfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  item_t       item,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_data,
    input  result_t     result,
    input  logic        result_valid,
    output int          errors,
    output int          pending
);

    localparam longint ACC_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_MIN = -64'sh0000_8000_0000_0000;

    logic [30:0] stiffness [4];
    logic [30:0] rest_length [4];
    longint      force_store [1024][3];
    bit          sat_mark [1024];
    result_t     expected_reads [$];

    function automatic bit [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic bit [63:0] int_sqrt(bit [63:0] x);
        bit [63:0] root = 0;
        bit [63:0] b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= root + b)
            begin
                x = x - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic longint scaled_component(longint f, longint d, inout bit clip);
        bit         neg = (f < 0) != (d < 0);
        bit [127:0] prod = {64'd0, magnitude(f)} * {64'd0, magnitude(d)};
        bit [127:0] q = prod >> 16;
        bit [127:0] lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
        if (q > lim)
        begin
            q = lim;
            clip = 1'b1;
        end
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic longint clamped_sum(longint a, longint v, inout bit mark);
        longint s = a + v;
        if (s > ACC_MAX)
        begin
            s = ACC_MAX;
            mark = 1'b1;
        end
        if (s < ACC_MIN)
        begin
            s = ACC_MIN;
            mark = 1'b1;
        end
        return s;
    endfunction

    task automatic apply_word(item_t w);
        result_t     r;
        longint      d [3];
        longint      f;
        longint      fc;
        bit [63:0]   sq;
        bit [63:0]   len;
        bit [63:0]   k;
        bit [63:0]   rh;
        bit          clip;
        int          a;
        int          b;
        a = w.first_vertex;
        b = w.second_vertex;
        if (w.opcode == OP_READ || w.opcode == OP_READ_CLEAR)
        begin
            r.vertex_read = w.first_vertex;
            r.force_x = force_store[a][0][47:0];
            r.force_y = force_store[a][1][47:0];
            r.force_z = force_store[a][2][47:0];
            r.saturated = sat_mark[a];
            expected_reads.push_back(r);
            if (w.opcode == OP_READ_CLEAR)
            begin
                for (int i = 0; i < 3; i++)
                    force_store[a][i] = 0;
                sat_mark[a] = 1'b0;
            end
        end
        else if (w.opcode == OP_ACCUMULATE)
        begin
            d[0] = longint'(w.second_pos_x) - longint'(w.first_pos_x);
            d[1] = longint'(w.second_pos_y) - longint'(w.first_pos_y);
            d[2] = longint'(w.second_pos_z) - longint'(w.first_pos_z);
            sq = 0;
            for (int i = 0; i < 3; i++)
                sq = sq + ((magnitude(d[i]) * magnitude(d[i])) >> 2);
            len = int_sqrt(sq);
            if (len != 0)
            begin
                k = {33'd0, stiffness[w.spring_type]};
                rh = {33'd0, rest_length[w.spring_type]} >> 1;
                f = longint'(k) - longint'((k * rh) / len);
                clip = 1'b0;
                for (int i = 0; i < 3; i++)
                begin
                    fc = scaled_component(f, d[i], clip);
                    force_store[a][i] = clamped_sum(force_store[a][i], fc, sat_mark[a]);
                    force_store[b][i] = clamped_sum(force_store[b][i], -fc, sat_mark[b]);
                end
                if (clip)
                begin
                    sat_mark[a] = 1'b1;
                    sat_mark[b] = 1'b1;
                end
            end
        end
    endtask

    initial
    begin
        errors = 0;
        for (int i = 0; i < 4; i++)
        begin
            stiffness[i] = REG_RESET;
            rest_length[i] = REG_RESET;
        end
        for (int v = 0; v < 1024; v++)
        begin
            sat_mark[v] = 1'b0;
            for (int i = 0; i < 3; i++)
                force_store[v][i] = 0;
        end
    end

    assign pending = expected_reads.size();

    always @(posedge clk)
    begin
        result_t e;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index < 4)
                    stiffness[cfg_index[1:0]] = cfg_data;
                else
                    rest_length[cfg_index[1:0]] = cfg_data;
            end
            if (result_valid)
            begin
                if (expected_reads.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("Unexpected result word: %p", result);
                end
                else
                begin
                    e = expected_reads.pop_front();
                    if (e !== result)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("Mismatch: expected %p, got %p", e, result);
                    end
                end
            end
            if (start && !busy)
                apply_word(item);
        end
    end

endmodule

>>> tb/sv/tb.sv
// Testbench top for the spring force accumulator: stimulus, configuration and verdict.
`timescale 1ns / 1ps

module tb;
    import sfa_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEMS_PER_PHASE = 175;
    localparam logic [30:0] REG_TOP = 31'h7FFF_FFFF;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    item_t       item = '0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [30:0] cfg_data = '0;
    result_t     result;
    logic        result_valid;
    int          errors;
    int          pending;
    int          cycles = 0;
    int          burst_left = 0;

    always #10 clk = ~clk;

    spring_force_accumulator uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .result(result), .result_valid(result_valid)
    );

    spring_force_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .result(result), .result_valid(result_valid),
        .errors(errors), .pending(pending)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_word(item_t w);
        start <= 1'b1;
        item <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
    endtask

    task automatic settle;
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_regs(logic [30:0] k [4], logic [30:0] rl [4]);
        settle();
        for (int i = 0; i < 8; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= (i < 4) ? k[i] : rl[i - 4];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic item_t make_word(logic [1:0] op, int a, int b, int t,
                                        logic signed [31:0] p [6]);
        item_t w;
        w.opcode = op;
        w.first_vertex = 10'(a);
        w.second_vertex = 10'(b);
        w.spring_type = 2'(t);
        w.first_pos_x = p[0];
        w.first_pos_y = p[1];
        w.first_pos_z = p[2];
        w.second_pos_x = p[3];
        w.second_pos_y = p[4];
        w.second_pos_z = p[5];
        return w;
    endfunction

    function automatic item_t random_word();
        logic signed [31:0] p [6];
        logic [1:0] op;
        int sel;
        int a;
        int b;
        int sh;
        sel = $urandom_range(0, 99);
        op = sel < 60 ? OP_ACCUMULATE : sel < 85 ? OP_READ : sel < 97 ? OP_READ_CLEAR : OP_UNUSED;
        a = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 7);
        b = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1023) : $urandom_range(0, 7);
        if ($urandom_range(0, 19) == 0)
            b = a;
        sh = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(4, 14);
        for (int i = 0; i < 6; i++)
            p[i] = $signed($urandom) >>> sh;
        return make_word(op, a, b, $urandom_range(0, 3), p);
    endfunction

    initial
    begin
        logic signed [31:0] p [6];
        logic [30:0] k [4];
        logic [30:0] rl [4];
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset configuration.
        p = '{default: 32'sd0};
        send_word(make_word(OP_READ, 0, 0, 0, p));
        send_word(make_word(OP_READ, 1023, 0, 0, p));
        send_word(make_word(OP_ACCUMULATE, 5, 5, 0, p));
        p = '{32'sd1, 32'sd0, 32'sd0, 32'sd2, 32'sd0, 32'sd0};
        send_word(make_word(OP_ACCUMULATE, 1, 2, 1, p));
        p = '{32'sd0, 32'sd0, 32'sd0, 32'sd196608, -32'sd65536, 32'sd131072};
        for (int t = 0; t < 4; t++)
            send_word(make_word(OP_ACCUMULATE, 1, 2, t, p));
        p = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
        send_word(make_word(OP_ACCUMULATE, 0, 1023, 2, p));
        send_word(make_word(OP_UNUSED, 3, 4, 3, p));
        send_word(make_word(OP_READ, 1, 0, 0, p));
        send_word(make_word(OP_READ_CLEAR, 2, 0, 0, p));
        send_word(make_word(OP_READ, 2, 0, 0, p));
        send_word(make_word(OP_READ_CLEAR, 0, 0, 0, p));
        send_word(make_word(OP_READ_CLEAR, 1023, 0, 0, p));

        for (int ph = 0; ph < 4; ph++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                case (ph)
                    0:
                    begin
                        k[i] = REG_TOP;
                        rl[i] = REG_TOP;
                    end
                    1:
                    begin
                        k[i] = '0;
                        rl[i] = '0;
                    end
                    2:
                    begin
                        k[i] = 31'($urandom_range(0, 32'h0010_0000));
                        rl[i] = 31'($urandom);
                    end
                    default:
                    begin
                        k[i] = 31'($urandom);
                        rl[i] = 31'($urandom_range(0, 32'h0004_0000));
                    end
                endcase
            end
            if (ph == 0)
            begin
                k[1] = 31'd0;
                rl[2] = 31'd0;
            end
            write_regs(k, rl);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_word(random_word());
        end

        settle();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
